// ----- rtl/dws_pkg.sv -----
`default_nettype none

package dws_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int KEY_W_DEF  = 32;
    localparam int KEY_IO_W   = 32;
    localparam int CNT_IO_W   = 5;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_PUSH_SORT  = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [KEY_IO_W-1:0] key_in;
        logic                descending;
    } t_in;

    typedef struct packed {
        logic [KEY_IO_W-1:0] key_out;
        logic [1:0]          status;
        logic [CNT_IO_W-1:0] count;
        logic                is_empty;
    } t_out;

endpackage

`default_nettype wire

// ----- rtl/deque_with_sorted_insert_core.sv -----
`default_nettype none
// Channel  Direction  Handshake                 Beat
// in       input      i_in_valid / o_in_stall   dws_pkg::t_in
// out      output     o_out_valid / i_out_stall dws_pkg::t_out
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (signed_keys)
//
// One item at a time. Each item ends in S_DONE, which loads the result register; pops first pass S_POP.
// A sorted push runs an insertion sort through the key memory (one read and one write port):
// each held key is read (S_SLD, S_SKEY), moved past out-of-order keys (S_SCMP), then placed.
// Synchronous active-low reset clears count, head pointer and control; key memory is not cleared.
// A stalled result holds in the output register; the next item is accepted meanwhile.

module deque_with_sorted_insert_core #(
    parameter int DEPTH     = dws_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = dws_pkg::KEY_W_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire dws_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output dws_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_data
);
    import dws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_SLD  = 3'd2;
    localparam logic [2:0] S_SKEY = 3'd3;
    localparam logic [2:0] S_SCMP = 3'd4;
    localparam logic [2:0] S_SPUT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rd_data;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [KEY_WIDTH-1:0] r_k, n_k;
    logic                 r_desc, n_desc;
    logic                 r_signed;
    t_out                 r_res, n_res;
    t_out                 r_out;
    logic                 r_out_valid;

    logic                 we, re;
    logic [AW-1:0]        waddr, raddr;
    logic [KEY_WIDTH-1:0] wdata;
    logic                 out_load;
    logic                 full, empty;
    logic [AW-1:0]        head_dec, head_inc;
    logic [KEY_WIDTH-1:0] key_new;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(idx);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return AW'(s);
    endfunction

    function automatic logic f_ooo(input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b,
                                   input logic desc, input logic sgn);
        logic [KEY_WIDTH-1:0] ax;
        logic [KEY_WIDTH-1:0] bx;
        ax = a;
        bx = b;
        if (sgn) begin
            ax[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
            bx[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
        end
        return desc ? (ax < bx) : (ax > bx);
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign key_new  = KEY_WIDTH'(i_in.key_in);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_desc  = r_desc;
        n_res   = r_res;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = r_head;
        raddr   = r_head;
        wdata   = key_new;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.key_out = '0;
                    n_res.status  = ST_OK;
                    n_state       = S_DONE;
                    case (i_in.opcode)
                        OP_PUSH_FRONT, OP_PUSH_SORT: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = head_dec;
                                n_head  = head_dec;
                                n_count = r_count + CW'(1);
                                if (i_in.opcode == OP_PUSH_SORT) begin
                                    n_i     = CW'(1);
                                    n_desc  = i_in.descending;
                                    n_state = S_SLD;
                                end
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = f_phys(r_head, r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                re      = 1'b1;
                                raddr   = r_head;
                                n_head  = head_inc;
                                n_count = r_count - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                re      = 1'b1;
                                raddr   = f_phys(r_head, r_count - CW'(1));
                                n_count = r_count - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.count    = CNT_IO_W'(n_count);
                    n_res.is_empty = (n_count == '0);
                end
            end
            S_POP: begin
                n_res.key_out = KEY_IO_W'(r_rd_data);
                n_state       = S_DONE;
            end
            S_SLD: begin
                if (r_i == r_count) begin
                    n_state = S_DONE;
                end else begin
                    re      = 1'b1;
                    raddr   = f_phys(r_head, r_i);
                    n_j     = r_i;
                    n_state = S_SKEY;
                end
            end
            S_SKEY: begin
                n_k     = r_rd_data;
                re      = 1'b1;
                raddr   = f_phys(r_head, r_j - CW'(1));
                n_state = S_SCMP;
            end
            S_SCMP: begin
                we    = 1'b1;
                waddr = f_phys(r_head, r_j);
                if (f_ooo(r_rd_data, r_k, r_desc, r_signed)) begin
                    wdata = r_rd_data;
                    n_j   = r_j - CW'(1);
                    if (r_j == CW'(1)) begin
                        n_state = S_SPUT;
                    end else begin
                        re    = 1'b1;
                        raddr = f_phys(r_head, r_j - CW'(2));
                    end
                end else begin
                    wdata   = r_k;
                    n_i     = r_i + CW'(1);
                    n_state = S_SLD;
                end
            end
            S_SPUT: begin
                we      = 1'b1;
                waddr   = r_head;
                wdata   = r_k;
                n_i     = r_i + CW'(1);
                n_state = S_SLD;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_desc <= n_desc;
        r_res  <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_signed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_signed <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dws_chk.sv -----
`default_nettype none

module dws_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire dws_pkg::t_out o_out
);
    import dws_pkg::*;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EMPTY |-> o_out.is_empty && o_out.key_out == '0)
        else $error("empty pop result inconsistent");

    a_full_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> !o_out.is_empty && o_out.key_out == '0)
        else $error("full push result inconsistent");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_empty |-> o_out.count == '0)
        else $error("empty flag with nonzero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

endmodule

bind deque_with_sorted_insert_core dws_chk u_dws_chk (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import dws_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int SORT_CYCLES = DEPTH * DEPTH / 2 + 3 * DEPTH + 8;
    localparam int SETTLE      = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_beat   = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_beat;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    // predictor state
    logic [KEY_IO_W-1:0] held_keys [DEPTH];
    int unsigned         held_n     = 0;
    logic                signed_cmp = 1'b0;
    t_out                pending_results [$];

    int unsigned err_count    = 0;
    int unsigned hold_left    = 0;
    bit          stall_random = 1'b0;
    bit          gaps_on      = 1'b0;

    deque_with_sorted_insert_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit goes_after(logic [KEY_IO_W-1:0] a, logic [KEY_IO_W-1:0] b,
                                      bit desc);
        if (signed_cmp)
            return desc ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
        return desc ? (a < b) : (a > b);
    endfunction

    function automatic t_out apply_op(t_in op_beat);
        t_out                res;
        logic [KEY_IO_W-1:0] k;
        int                  j;
        res = '0;
        res.status = ST_OK;
        case (op_beat.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_SORT: begin
                if (held_n >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (op_beat.opcode == OP_PUSH_BACK) begin
                    held_keys[held_n] = op_beat.key_in;
                    held_n++;
                end else begin
                    for (int i = held_n; i > 0; i--) held_keys[i] = held_keys[i-1];
                    held_keys[0] = op_beat.key_in;
                    held_n++;
                    if (op_beat.opcode == OP_PUSH_SORT) begin
                        // stable insertion sort, new key stays ahead of equal keys
                        for (int i = 1; i < held_n; i++) begin
                            k = held_keys[i];
                            j = i;
                            while (j > 0 && goes_after(held_keys[j-1], k, op_beat.descending)) begin
                                held_keys[j] = held_keys[j-1];
                                j--;
                            end
                            held_keys[j] = k;
                        end
                    end
                end
            end
            OP_POP_FRONT: begin
                if (held_n == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key_out = held_keys[0];
                    held_n--;
                    for (int i = 0; i < held_n; i++) held_keys[i] = held_keys[i+1];
                end
            end
            OP_POP_BACK: begin
                if (held_n == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held_n--;
                    res.key_out = held_keys[held_n];
                end
            end
            default: begin
            end
        endcase
        res.count    = CNT_IO_W'(held_n);
        res.is_empty = (held_n == 0);
        return res;
    endfunction

    task automatic send_op(logic [2:0] op, logic [KEY_IO_W-1:0] key, logic desc);
        int gap;
        gap = 0;
        if (gaps_on) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap = 0;
                10, 11, 12, 13, 14, 15, 16: gap = $urandom_range(1, 3);
                17, 18: gap = $urandom_range(4, 10);
                default: gap = $urandom_range(20, 50);
            endcase
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_beat  <= '{opcode: op, key_in: key, descending: desc};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(apply_op(in_beat));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_signed_mode(logic mode);
        wait_idle();
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        signed_cmp = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_edge_cases();
        send_op(OP_POP_FRONT, '1, 1'b0);
        send_op(OP_POP_BACK, '1, 1'b1);
        for (int op = OP_POP_BACK + 1; op < 8; op++)
            send_op(3'(op), $urandom(), 1'(op));
        send_op(OP_PUSH_FRONT, 32'h0000_0000, 1'b1);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
        send_op(OP_PUSH_SORT, 32'h8000_0000, 1'b0);
        send_op(OP_PUSH_SORT, 32'h7FFF_FFFF, 1'b1);
        send_op(OP_PUSH_SORT, 32'h7FFF_FFFF, 1'b0);
        send_op(OP_PUSH_SORT, 32'h0000_0000, 1'b1);
        while (held_n < DEPTH) send_op(OP_PUSH_BACK, $urandom(), 1'b0);
        send_op(OP_PUSH_FRONT, 32'h1234_5678, 1'b0);
        send_op(OP_PUSH_BACK, 32'h1234_5678, 1'b0);
        send_op(OP_PUSH_SORT, 32'h1234_5678, 1'b1);
        send_op(OP_POP_FRONT, 32'h0, 1'b0);
        send_op(OP_POP_BACK, 32'h0, 1'b0);
    endtask

    task automatic test_signed_order();
        write_signed_mode(1'b1);
        while (held_n > 0) send_op(OP_POP_FRONT, 32'h0, 1'b0);
        send_op(OP_PUSH_SORT, 32'h8000_0000, 1'b0);
        send_op(OP_PUSH_SORT, 32'h7FFF_FFFF, 1'b0);
        send_op(OP_PUSH_SORT, 32'hFFFF_FFFF, 1'b0);
        send_op(OP_PUSH_SORT, 32'h0000_0000, 1'b0);
        send_op(OP_PUSH_SORT, 32'h0000_0001, 1'b1);
        repeat (5) send_op(OP_POP_FRONT, 32'h0, 1'b0);
    endtask

    task automatic test_random_ops(int unsigned n);
        int unsigned         bias;
        int unsigned         r;
        logic [2:0]          op;
        logic [KEY_IO_W-1:0] key;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                bias         = $urandom_range(0, 2);
                gaps_on      = ($urandom_range(0, 3) != 0);
                stall_random = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                op = 3'(OP_POP_BACK + $urandom_range(1, 3));
            else if (r < (bias == 0 ? 75 : (bias == 1 ? 30 : 52)))
                op = 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_SORT));
            else
                op = 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
            case ($urandom_range(0, 3))
                0: key = $urandom();
                1: key = 32'($urandom_range(0, 7));
                2: key = 32'h7FFF_FFFF + 32'($urandom_range(0, 3)) - 32'd1;
                default: key = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            endcase
            send_op(op, key, 1'($urandom_range(0, 1)));
        end
    endtask

    // receiver held off long enough that the block backs up into its input
    task automatic test_output_hold();
        gaps_on      = 1'b0;
        stall_random = 1'b0;
        hold_left    = 400;
        for (int i = 0; i < 30; i++)
            send_op(3'($urandom_range(OP_PUSH_FRONT, OP_POP_BACK)), $urandom(),
                    1'($urandom_range(0, 1)));
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++) begin
            test_random_ops(20);
            wait_idle();
        end
    endtask

    initial begin : out_side
        int run;
        run = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (!stall_random) begin
                out_stall <= 1'b0;
            end else if (run > 0) begin
                run--;
            end else begin
                out_stall <= ($urandom_range(0, 2) == 0);
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 3);
            end
        end
    end

    always @(posedge clk) begin : check_out
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected beat: key_out %h status %0d count %0d",
                       out_beat.key_out, out_beat.status, out_beat.count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_beat.key_out !== want.key_out) begin
                    $error("key_out: expected %h, got %h", want.key_out, out_beat.key_out);
                    err_count++;
                end
                if (out_beat.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_beat.status);
                    err_count++;
                end
                if (out_beat.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, out_beat.count);
                    err_count++;
                end
                if (out_beat.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, out_beat.is_empty);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_edge_cases();
        test_signed_order();
        test_random_ops(450);
        write_signed_mode(1'b0);
        test_random_ops(450);
        test_output_hold();
        write_signed_mode(1'b1);
        test_random_ops(450);
        test_sender_pause();
        write_signed_mode(1'b0);
        test_random_ops(400);
        wait_idle();
        repeat (SORT_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dws_pkg.sv
rtl/deque_with_sorted_insert_core.sv
rtl/dws_chk.sv
sim/testbench.sv
